### design/strongly_connected_components_defines.svh
// Assertion macros shared by the strongly connected components design.
// Depends on nothing; included by files that carry assertions.
`ifndef STRONGLY_CONNECTED_COMPONENTS_DEFINES_SVH
`define STRONGLY_CONNECTED_COMPONENTS_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define SCC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define SCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### design/scc_pkg.sv
// Package for the strongly connected components block: command codes,
// controller states and the controller/datapath command and status structs.
`default_nettype none
package scc_pkg;
    localparam int MaxVerticesDefault = 64;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_RUN = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FROOT,
        ST_FREAD,
        ST_FSTEP,
        ST_RFETCH,
        ST_RROOT,
        ST_RREAD,
        ST_RSTEP,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic load;        // latch a new request
        logic add_edge;    // write an edge into both matrices
        logic clear_row;   // clear row at clear counter
        logic fwd_root;    // start forward walk at lowest unvisited
        logic rev_root;    // start reverse walk at next finish entry
        logic step;        // push or pop based on adjacency row
        logic emit;        // present component on the output
        logic emit_empty;  // present the empty result
    } cmd_bus_t;

    typedef struct packed {
        logic clear_done;
        logic fwd_done;     // no unvisited vertex left in the forward pass
        logic rev_done;     // finish list exhausted
        logic rev_skip;     // next finish entry already visited
        logic stack_last;   // the step pops the last stack entry
        logic mask_empty;
        logic out_busy;
    } status_t;
endpackage
`default_nettype wire

### design/strongly_connected_components.sv
// Kosaraju SCC decomposer. An add-edge request is a row read, then a write into
// both adjacency RAMs, input stalled; a clear zeroes every row. A decompose run
// pushes and pops each subgraph vertex once per pass, with extra steps for each
// root, skipped finish entry and component, plus output stalls. One request is
// in flight at a time. Reset clears control state, then a clearing pass zeroes
// every edge.
`default_nettype none
module strongly_connected_components
    import scc_pkg::*;
#(
    parameter int MAX_VERTICES = MaxVerticesDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [5:0]  src_vertex,
    input  wire logic [5:0]  dst_vertex,
    input  wire logic [63:0] subgraph_mask,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      scc_members,
    output logic [6:0]       scc_size,
    output logic [5:0]       scc_index,
    output logic             last
);
    // The controller sequences each request; the datapath holds the graph,
    // the walk stack and the finish list.
    cmd_bus_t cmd_bus;
    status_t  status;

    scc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .status(status), .cmd_bus(cmd_bus));

    scc_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd_bus(cmd_bus), .status(status),
        .src_vertex(src_vertex), .dst_vertex(dst_vertex),
        .subgraph_mask(subgraph_mask), .out_valid(out_valid),
        .out_stall(out_stall), .scc_members(scc_members), .scc_size(scc_size),
        .scc_index(scc_index), .last(last));
endmodule
`default_nettype wire

### design/scc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`default_nettype none
module scc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

### design/scc_datapath.sv
// Datapath: adjacency memories, walk stack, finish list and result register.
// Depends on scc_pkg, scc_ram and strongly_connected_components_defines.svh.
`default_nettype none
`include "strongly_connected_components_defines.svh"
module scc_datapath
    import scc_pkg::*;
#(
    parameter int MAX_VERTICES = MaxVerticesDefault
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_bus_t    cmd_bus,
    output status_t          status,
    input  wire logic [5:0]  src_vertex,
    input  wire logic [5:0]  dst_vertex,
    input  wire logic [63:0] subgraph_mask,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      scc_members,
    output logic [6:0]       scc_size,
    output logic [5:0]       scc_index,
    output logic             last
);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic [MAX_VERTICES-1:0] mask_reg, unvisited_reg, unvisited_next, comp_reg;
    logic [AW-1:0] src_reg, dst_reg, clr_reg;
    logic [CW-1:0] depth_reg, fin_cnt_reg, fin_ptr_reg;
    logic [AW-1:0] top_reg;
    logic [5:0]    idx_reg;
    logic          src_ok_reg;
    logic          out_valid_reg;
    logic [63:0]   members_reg;
    logic [6:0]    size_reg;
    logic [6:0]    comp_size_reg;
    logic [5:0]    index_reg;
    logic          last_reg;

    // Stack and finish list as RAMs; adjacency as two RAMs.
    logic [AW-1:0] stk_waddr, stk_raddr, stk_rdata, stk_wdata;
    logic          stk_we;
    logic [AW-1:0] fin_waddr, fin_raddr, fin_rdata;
    logic          fin_we;
    logic [MAX_VERTICES-1:0] fwd_rdata, rev_rdata, fwd_wdata, rev_wdata;
    logic [AW-1:0] fwd_waddr, rev_waddr, adj_raddr;
    logic          adj_we;
    logic          reverse_reg;

    // Rows are read-modify-written: edge add reads rows first.
    logic [MAX_VERTICES-1:0] next_row;
    logic [AW-1:0] hi_bit, low_bit;
    logic          any_next, any_unv;

    assign next_row = (reverse_reg ? rev_rdata : fwd_rdata) & unvisited_reg;

    always_comb
    begin
        hi_bit = '0;
        any_next = 1'b0;
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            if (next_row[i])
            begin
                hi_bit = AW'(i);
                any_next = 1'b1;
            end
        end
        low_bit = '0;
        any_unv = 1'b0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--)
        begin
            if (unvisited_reg[i])
            begin
                low_bit = AW'(i);
                any_unv = 1'b1;
            end
        end
    end

    // Edge add is a read-modify-write: load reads, add_edge writes.
    assign adj_we = cmd_bus.add_edge || cmd_bus.clear_row;
    assign fwd_waddr = cmd_bus.clear_row ? clr_reg : src_reg;
    assign rev_waddr = cmd_bus.clear_row ? clr_reg : dst_reg;
    always_comb
    begin
        fwd_wdata = '0;
        rev_wdata = '0;
        if (!cmd_bus.clear_row)
        begin
            fwd_wdata = fwd_rdata;
            rev_wdata = rev_rdata;
            fwd_wdata[dst_reg] = 1'b1;
            rev_wdata[src_reg] = 1'b1;
        end
    end
    logic [AW-1:0] fwd_raddr, rev_raddr;
    assign fwd_raddr = cmd_bus.load ? src_vertex[AW-1:0] : adj_raddr;
    assign rev_raddr = cmd_bus.load ? dst_vertex[AW-1:0] : adj_raddr;

    scc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_fwd (
        .clk(clk), .we(adj_we && (src_ok_reg || cmd_bus.clear_row)),
        .waddr(fwd_waddr), .wdata(fwd_wdata), .raddr(fwd_raddr), .rdata(fwd_rdata));
    scc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_rev (
        .clk(clk), .we(adj_we && (src_ok_reg || cmd_bus.clear_row)),
        .waddr(rev_waddr), .wdata(rev_wdata), .raddr(rev_raddr), .rdata(rev_rdata));
    scc_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata));
    scc_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_fin (
        .clk(clk), .we(fin_we), .waddr(fin_waddr), .wdata(top_reg),
        .raddr(fin_raddr), .rdata(fin_rdata));

    // Outside a load, the adjacency read addresses the current stack top.
    assign adj_raddr = top_reg;
    logic push, pop, fwd_start, rev_start;
    assign push = cmd_bus.step && any_next;
    assign pop = cmd_bus.step && !any_next;
    // A forward root with nothing left unvisited switches to the reverse pass.
    assign fwd_start = cmd_bus.fwd_root && any_unv;
    assign rev_start = cmd_bus.fwd_root && !any_unv;
    assign stk_we = push || fwd_start || (cmd_bus.rev_root && !status.rev_skip);
    assign stk_waddr = depth_reg[AW-1:0];
    assign stk_wdata = push ? hi_bit : (fwd_start ? low_bit : fin_rdata);
    // Entry below the top, used after a pop.
    assign stk_raddr = depth_reg[AW-1:0] - AW'(2);
    assign fin_we = pop && !reverse_reg;
    assign fin_waddr = fin_cnt_reg[AW-1:0];
    assign fin_raddr = fin_ptr_reg[AW-1:0] - AW'(1);

    always_comb
    begin
        unvisited_next = unvisited_reg;
        if (cmd_bus.load)
        begin
            unvisited_next = subgraph_mask[MAX_VERTICES-1:0];
        end
        else if (rev_start)
        begin
            unvisited_next = mask_reg;
        end
        else if (push)
        begin
            unvisited_next[hi_bit] = 1'b0;
        end
        else if (fwd_start)
        begin
            unvisited_next[low_bit] = 1'b0;
        end
        else if (cmd_bus.rev_root && !status.rev_skip)
        begin
            unvisited_next[fin_rdata] = 1'b0;
        end
    end

    // Popping: the stack RAM read of the entry below the top is already
    // registered, since stk_raddr tracks depth continuously.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            fin_cnt_reg <= '0;
            fin_ptr_reg <= '0;
            reverse_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            clr_reg <= '0;
            idx_reg <= '0;
            unvisited_reg <= '0;
            comp_reg <= '0;
            comp_size_reg <= '0;
            src_ok_reg <= 1'b0;
        end
        else
        begin
            unvisited_reg <= unvisited_next;
            if (cmd_bus.load)
            begin
                mask_reg <= subgraph_mask[MAX_VERTICES-1:0];
                src_reg <= src_vertex[AW-1:0];
                dst_reg <= dst_vertex[AW-1:0];
                src_ok_reg <= (32'(src_vertex) < MAX_VERTICES)
                           && (32'(dst_vertex) < MAX_VERTICES);
                clr_reg <= '0;
                fin_cnt_reg <= '0;
                depth_reg <= '0;
                reverse_reg <= 1'b0;
                idx_reg <= '0;
            end
            if (cmd_bus.clear_row)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (fwd_start)
            begin
                top_reg <= low_bit;
                depth_reg <= CW'(1);
            end
            if (rev_start)
            begin
                reverse_reg <= 1'b1;
                fin_ptr_reg <= fin_cnt_reg;
            end
            if (cmd_bus.rev_root)
            begin
                fin_ptr_reg <= fin_ptr_reg - CW'(1);
                if (!status.rev_skip)
                begin
                    top_reg <= fin_rdata;
                    depth_reg <= CW'(1);
                    comp_reg <= MAX_VERTICES'(1) << fin_rdata;
                    comp_size_reg <= 7'd1;
                end
            end
            if (push)
            begin
                top_reg <= hi_bit;
                depth_reg <= depth_reg + CW'(1);
                if (reverse_reg)
                begin
                    comp_reg[hi_bit] <= 1'b1;
                    comp_size_reg <= comp_size_reg + 7'd1;
                end
            end
            if (pop)
            begin
                top_reg <= stk_rdata;
                depth_reg <= depth_reg - CW'(1);
                if (!reverse_reg)
                begin
                    fin_cnt_reg <= fin_cnt_reg + CW'(1);
                end
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd_bus.emit)
            begin
                out_valid_reg <= 1'b1;
                members_reg <= 64'(comp_reg);
                size_reg <= comp_size_reg;
                index_reg <= idx_reg;
                last_reg <= !any_unv;
                idx_reg <= idx_reg + 6'd1;
            end
            if (cmd_bus.emit_empty)
            begin
                out_valid_reg <= 1'b1;
                members_reg <= '0;
                size_reg <= '0;
                index_reg <= '0;
                last_reg <= 1'b1;
            end
        end
    end

    // The last component is the one that leaves no subgraph vertex unvisited.
    assign status.clear_done = (clr_reg == AW'(MAX_VERTICES - 1));
    assign status.fwd_done = !any_unv;
    assign status.rev_done = (fin_ptr_reg == '0);
    assign status.rev_skip = !unvisited_reg[fin_rdata];
    assign status.stack_last = (depth_reg == CW'(1)) && !any_next;
    assign status.mask_empty = (mask_reg == '0);
    assign status.out_busy = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign scc_members = members_reg;
    assign scc_size = size_reg;
    assign scc_index = index_reg;
    assign last = last_reg;

    `SCC_ASSERT_IMPL(a_depth_bound, 1'b1, depth_reg <= CW'(MAX_VERTICES),
        "walk stack overflow")
    `SCC_ASSERT_NEXT(a_push_marks, push, !unvisited_reg[top_reg],
        "pushed vertex still unvisited")
    `SCC_ASSERT_IMPL(a_fin_bound, 1'b1, fin_cnt_reg <= CW'(MAX_VERTICES),
        "finish list overflow")
endmodule
`default_nettype wire

### design/scc_ctrl.sv
// Controller state machine sequencing clears, edge adds and the two walks.
// Depends on scc_pkg and strongly_connected_components_defines.svh.
`default_nettype none
`include "strongly_connected_components_defines.svh"
module scc_ctrl
    import scc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] cmd,
    input  wire status_t    status,
    output cmd_bus_t        cmd_bus
);
    state_t state_reg, state_next;
    logic   add_reg, add_next;
    logic   accept;

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        add_next = add_reg;
        case (state_reg)
            ST_IDLE:
            begin
                add_next = 1'b0;
                if (accept)
                begin
                    case (cmd_t'(cmd))
                        CMD_ADD: add_next = 1'b1;
                        CMD_CLEAR: state_next = ST_CLEAR;
                        CMD_RUN: state_next = ST_FROOT;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: if (status.clear_done) state_next = ST_IDLE;
            ST_FROOT:
            begin
                if (status.mask_empty) state_next = ST_EMPTY;
                else if (status.fwd_done) state_next = ST_RFETCH;
                else state_next = ST_FREAD;
            end
            ST_FREAD: state_next = ST_FSTEP;
            ST_FSTEP: state_next = status.stack_last ? ST_FROOT : ST_FREAD;
            // The finish list read is registered, so ST_RFETCH waits for it before ST_RROOT.
            ST_RFETCH: state_next = ST_RROOT;
            ST_RROOT:
            begin
                if (status.rev_done) state_next = ST_IDLE;
                else if (!status.rev_skip) state_next = ST_RREAD;
                else state_next = ST_RFETCH;
            end
            ST_RREAD: state_next = ST_RSTEP;
            ST_RSTEP: state_next = status.stack_last ? ST_EMIT : ST_RREAD;
            ST_EMIT: if (!status.out_busy) state_next = ST_RROOT;
            ST_EMPTY: if (!status.out_busy) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_bus = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = add_reg;
                cmd_bus.add_edge = add_reg;
                cmd_bus.load = accept;
            end
            ST_CLEAR: cmd_bus.clear_row = 1'b1;
            ST_FROOT: cmd_bus.fwd_root = !status.mask_empty;
            ST_FSTEP, ST_RSTEP: cmd_bus.step = 1'b1;
            ST_RROOT: cmd_bus.rev_root = !status.rev_done;
            ST_EMIT: cmd_bus.emit = !status.out_busy;
            ST_EMPTY: cmd_bus.emit_empty = !status.out_busy;
            default: cmd_bus = '0;
        endcase
    end

    // Reset starts with a clearing pass over the adjacency memories.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            add_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            add_reg <= add_next;
        end
    end

    `SCC_ASSERT_IMPL(a_stall_busy, state_reg != ST_IDLE, in_stall,
        "request accepted while busy")
    `SCC_ASSERT_NEXT(a_step_follows_read, state_reg == ST_FREAD, state_reg == ST_FSTEP,
        "read not followed by step")
    `SCC_ASSERT_IMPL(a_one_emit, 1'b1, !(cmd_bus.emit && cmd_bus.emit_empty),
        "two emits at once")
endmodule
`default_nettype wire

### dv/tb_strongly_connected_components.sv
// Self-checking testbench for the strongly connected components decomposer.
// Depends on scc_pkg and the strongly_connected_components design files.
`timescale 1ns / 100ps
`default_nettype none
module tb_strongly_connected_components;
    import scc_pkg::*;

    localparam int WatchdogLimit = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [5:0]  src_vertex;
    logic [5:0]  dst_vertex;
    logic [63:0] subgraph_mask;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] scc_members;
    logic [6:0]  scc_size;
    logic [5:0]  scc_index;
    logic        last;

    strongly_connected_components dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .src_vertex(src_vertex), .dst_vertex(dst_vertex),
        .subgraph_mask(subgraph_mask),
        .out_valid(out_valid), .out_stall(out_stall),
        .scc_members(scc_members), .scc_size(scc_size),
        .scc_index(scc_index), .last(last)
    );

    // One expected component, as the block should present it.
    typedef struct packed {
        logic [63:0] members;
        logic [6:0]  size;
        logic [5:0]  index;
        logic        last;
    } component_t;

    component_t pending_components[$];

    // Shadow graph, kept in step with every accepted request.
    logic [63:0] fwd_rows[64];
    logic [63:0] rev_rows[64];

    int error_count;
    int idle_cycles;
    bit hold_off;
    bit stim_done;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Iterative depth-first walk. In the forward direction it appends to the
    // finishing order; in the reverse direction it collects one component.
    function automatic logic [63:0] graph_walk(input int root, input bit reverse,
                                               inout logic [63:0] unseen,
                                               inout int order[$]);
        int stack[$];
        int top;
        int w;
        logic [63:0] next;
        logic [63:0] group;
        group = '0;
        unseen[root] = 1'b0;
        group[root] = 1'b1;
        stack.push_back(root);
        while (stack.size() > 0)
        begin
            top = stack[$];
            next = (reverse ? rev_rows[top] : fwd_rows[top]) & unseen;
            if (next != 0)
            begin
                w = 63;
                while (!next[w])
                    w--;
                unseen[w] = 1'b0;
                group[w] = 1'b1;
                stack.push_back(w);
            end
            else
            begin
                if (!reverse)
                    order.push_back(top);
                void'(stack.pop_back());
            end
        end
        return group;
    endfunction

    // Applies one accepted request to the shadow graph and queues the
    // components that a decompose request should produce, in output order.
    task automatic predict_components(input logic [1:0] c, input logic [5:0] s,
                                      input logic [5:0] d, input logic [63:0] m);
        logic [63:0] unseen;
        logic [63:0] group;
        int order[$];
        int n;
        int v;
        component_t item;
        case (cmd_t'(c))
            CMD_ADD:
            begin
                fwd_rows[s][d] = 1'b1;
                rev_rows[d][s] = 1'b1;
            end
            CMD_CLEAR:
            begin
                for (int r = 0; r < 64; r++)
                begin
                    fwd_rows[r] = '0;
                    rev_rows[r] = '0;
                end
            end
            CMD_RUN:
            begin
                if (m == 0)
                begin
                    item = '{members: '0, size: '0, index: '0, last: 1'b1};
                    pending_components.push_back(item);
                end
                else
                begin
                    unseen = m;
                    for (v = 0; v < 64; v++)
                        if (unseen[v])
                            void'(graph_walk(v, 1'b0, unseen, order));
                    unseen = m;
                    n = 0;
                    for (int i = order.size() - 1; i >= 0; i--)
                    begin
                        v = order[i];
                        if (unseen[v])
                        begin
                            group = graph_walk(v, 1'b1, unseen, order);
                            item.members = group;
                            item.size = 7'($countones(group));
                            item.index = 6'(n);
                            item.last = 1'b0;
                            pending_components.push_back(item);
                            n++;
                        end
                    end
                    pending_components[$].last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    // Sends one request, opening a new burst after a random gap when the
    // current one is used up, and holds the payload until it is accepted.
    int burst_left;
    task automatic send_request(input logic [1:0] c, input logic [5:0] s,
                                input logic [5:0] d, input logic [63:0] m);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd <= c;
        src_vertex <= s;
        dst_vertex <= d;
        subgraph_mask <= m;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_components(c, s, d, m);
    endtask

    // Waits until every queued component has come out, then a little longer.
    task automatic drain_outputs();
        while (pending_components.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // Directed table: edges forming a cycle among 0..2, a self loop, a chain,
    // extreme vertices, and runs on empty, partial and full masks. Every row is
    // checked against the predictor; the first run, an empty mask right after
    // reset, also has its result typed in below.
    typedef struct {
        logic [1:0]  c;
        logic [5:0]  s;
        logic [5:0]  d;
        logic [63:0] m;
    } stim_row_t;

    stim_row_t directed_rows[] = '{
        '{CMD_RUN,   6'd0,  6'd0,  64'h0},
        '{CMD_RUN,   6'd0,  6'd0,  64'hFFFF_FFFF_FFFF_FFFF},
        '{CMD_ADD,   6'd0,  6'd1,  64'h0},
        '{CMD_ADD,   6'd1,  6'd2,  64'h0},
        '{CMD_ADD,   6'd2,  6'd0,  64'h0},
        '{CMD_ADD,   6'd2,  6'd3,  64'h0},
        '{CMD_ADD,   6'd3,  6'd3,  64'h0},
        '{CMD_ADD,   6'd3,  6'd3,  64'h0},
        '{CMD_ADD,   6'd63, 6'd0,  64'h0},
        '{CMD_ADD,   6'd0,  6'd63, 64'h0},
        '{CMD_NONE,  6'd63, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF},
        '{CMD_RUN,   6'd0,  6'd0,  64'h0000_0000_0000_000F},
        '{CMD_RUN,   6'd0,  6'd0,  64'h8000_0000_0000_0007},
        '{CMD_RUN,   6'd0,  6'd0,  64'h0000_0000_0000_000A},
        '{CMD_RUN,   6'd0,  6'd0,  64'hFFFF_FFFF_FFFF_FFFF},
        '{CMD_CLEAR, 6'd0,  6'd0,  64'h0},
        '{CMD_RUN,   6'd0,  6'd0,  64'h8000_0000_0000_0001},
        '{CMD_RUN,   6'd0,  6'd0,  64'h0}
    };

    // Output checker with its own stall pattern; hold_off forces a long stall.
    always @(posedge clk)
    begin
        component_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_components.size() == 0)
                report_mismatch("unexpected component", scc_members, 64'h0);
            else
            begin
                want = pending_components.pop_front();
                if (scc_members !== want.members)
                    report_mismatch("scc_members", scc_members, want.members);
                if (scc_size !== want.size)
                    report_mismatch("scc_size", 64'(scc_size), 64'(want.size));
                if (scc_index !== want.index)
                    report_mismatch("scc_index", 64'(scc_index), 64'(want.index));
                if (last !== want.last)
                    report_mismatch("last", 64'(last), 64'(want.last));
            end
        end
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    // Watchdog on cycles with no accepted request or result.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Long receiver hold-off while the sender keeps offering runs.
    initial
    begin
        hold_off <= 1'b0;
        wait (stim_done == 1'b0 && rst_n);
        repeat (3000) @(posedge clk);
        hold_off <= 1'b1;
        repeat (1500) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        logic [1:0] c;
        logic [63:0] m;
        int kind;
        error_count = 0;
        burst_left = 0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_NONE;
        src_vertex = '0;
        dst_vertex = '0;
        subgraph_mask = '0;
        for (int r = 0; r < 64; r++)
        begin
            fwd_rows[r] = '0;
            rev_rows[r] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].c, directed_rows[i].s,
                         directed_rows[i].d, directed_rows[i].m);
            // The very first run must be the empty result, read off directly.
            if (i == 0 && pending_components.size() == 1 &&
                pending_components[0] !== component_t'{64'h0, 7'd0, 6'd0, 1'b1})
                report_mismatch("empty run prediction", '0, '0);
        end

        // Random part: graphs of random density, decomposed over random
        // masks, with stray clears and the unused code mixed in.
        for (int g = 0; g < 162; g++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                c = CMD_ADD;
                m = {$urandom, $urandom};
            end
            else if (kind < 90)
            begin
                c = CMD_RUN;
                case ($urandom_range(0, 3))
                    0: m = {$urandom, $urandom};
                    1: m = 64'(($urandom & 32'hFF));
                    2: m = ~64'h0;
                    default: m = {$urandom, $urandom} & {$urandom, $urandom};
                endcase
            end
            else if (kind < 95)
            begin
                c = CMD_CLEAR;
                m = {$urandom, $urandom};
            end
            else
            begin
                c = CMD_NONE;
                m = {$urandom, $urandom};
            end
            // Keep most edges among low vertices so components form.
            if ($urandom_range(0, 3) != 0)
                send_request(c, 6'($urandom_range(0, 11)), 6'($urandom_range(0, 11)), m);
            else
                send_request(c, 6'($urandom), 6'($urandom), m);
        end
        in_valid <= 1'b0;

        drain_outputs();
        stim_done = 1'b1;
        if (error_count == 0 && pending_components.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

### strongly_connected_components.f
+incdir+design
design/scc_pkg.sv
design/scc_ram.sv
design/scc_datapath.sv
design/scc_ctrl.sv
design/strongly_connected_components.sv
dv/tb_strongly_connected_components.sv
